[rtl/core/rcfd_pkg.sv]
// ----------------------------------------------------------------------------
// rcfd_pkg: shared definitions for the RC channel frame decoder
// Frame layout constants, configuration register indexes, the frame-end
// control struct and the channel clamp function.
// ----------------------------------------------------------------------------
package rcfd_pkg;

    // Field widths.
    localparam int BYTE_W = 8;
    localparam int CHAN_W = 16;
    localparam int POS_W  = 5;
    localparam int CHIX_W = 4;

    // Frame layout: two header bytes, channel words, then a check word.
    localparam int FRAME_LEN    = 32;
    localparam int SUM_BYTES    = 30;
    localparam int OUT_CHANNELS = 10;

    localparam logic [BYTE_W-1:0] HDR0       = 8'h20;
    localparam logic [BYTE_W-1:0] HDR1       = 8'h40;
    localparam logic [CHAN_W-1:0] SUM_TARGET = 16'hFFFF;

    // Default channel count and clamp limits after reset.
    localparam int                NUM_CHANNELS_DEF = 10;
    localparam logic [CHAN_W-1:0] CLAMP_LOW_RST    = 16'd1000;
    localparam logic [CHAN_W-1:0] CLAMP_HIGH_RST   = 16'd2000;

    // Configuration register indexes.
    localparam int               CFG_IDX_W          = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CLAMP_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CLAMP_HIGH = 2'd1;

    // Frame-end event from the byte tracker to the channel holder.
    typedef struct packed {
        logic valid;
        logic ok;
    } t_frame_end;

    // Raise to the low limit first, then cut to the high limit.
    function automatic logic [CHAN_W-1:0] clamp_chan(
        input logic [CHAN_W-1:0] v,
        input logic [CHAN_W-1:0] lo,
        input logic [CHAN_W-1:0] hi
    );
        logic [CHAN_W-1:0] t;
        t = (v < lo) ? lo : v;
        return (t > hi) ? hi : t;
    endfunction

endpackage

[rtl/core/rcfd_in_reg.sv]
// ----------------------------------------------------------------------------
// rcfd_in_reg: input byte register
// Holds one received byte until the frame tracker takes it, so the
// upstream link sees a registered stage.
// ----------------------------------------------------------------------------
module rcfd_in_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_valid,
    output logic                        o_s_ready,
    input  logic [rcfd_pkg::BYTE_W-1:0] i_s_byte,
    output logic                        o_valid,
    output logic [rcfd_pkg::BYTE_W-1:0] o_byte,
    input  logic                        i_take
);

    logic                        r_valid;
    logic                        n_valid;
    logic [rcfd_pkg::BYTE_W-1:0] r_byte;

    // The stage is free when empty or when its word leaves this cycle.
    assign o_s_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (i_s_valid && o_s_ready) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_valid && o_s_ready) begin
            r_byte <= i_s_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    // A held word that is not taken stays in place.
    a_hold_untaken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_take) |=> (r_valid && $stable(r_byte)))
        else $error("input word lost or changed while waiting");

endmodule

[rtl/core/rcfd_frame_track.sv]
// ----------------------------------------------------------------------------
// rcfd_frame_track: byte position, checksum and channel assembly
// Counts bytes into 32-byte frames, accumulates the checksum, checks the
// header and assembles the little-endian channel words.
// ----------------------------------------------------------------------------
module rcfd_frame_track #(
    parameter int NUM_CHANNELS = rcfd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_valid,
    input  logic [rcfd_pkg::BYTE_W-1:0]                    i_byte,
    output logic                                           o_take,
    input  logic                                           i_out_free,
    output rcfd_pkg::t_frame_end                           o_frame_end,
    output logic [NUM_CHANNELS-1:0][rcfd_pkg::CHAN_W-1:0]  o_pending
);

    localparam logic [rcfd_pkg::POS_W-1:0] POS_LAST =
        rcfd_pkg::POS_W'(rcfd_pkg::FRAME_LEN - 1);
    localparam logic [rcfd_pkg::POS_W-1:0] POS_SUM_END =
        rcfd_pkg::POS_W'(rcfd_pkg::SUM_BYTES);
    localparam logic [rcfd_pkg::POS_W-1:0] POS_CHAN0 = 5'd2;

    logic [rcfd_pkg::POS_W-1:0]                   r_pos;
    logic [rcfd_pkg::POS_W-1:0]                   n_pos;
    logic [rcfd_pkg::CHAN_W-1:0]                  r_sum;
    logic [rcfd_pkg::CHAN_W-1:0]                  n_sum;
    logic                                         r_hdr_ok;
    logic                                         n_hdr_ok;
    logic [rcfd_pkg::BYTE_W-1:0]                  r_sum_lo;
    logic [NUM_CHANNELS-1:0][rcfd_pkg::CHAN_W-1:0] r_pending;

    logic                         is_last;
    logic                         in_chan;
    logic [rcfd_pkg::POS_W-1:0]   pos_off;
    logic [rcfd_pkg::CHIX_W-1:0]  chan_ix;
    logic [rcfd_pkg::CHAN_W-1:0]  check_word;
    logic [rcfd_pkg::CHAN_W-1:0]  total;

    // A frame's last byte waits until the result register can take it.
    assign is_last = (r_pos == POS_LAST);
    assign o_take  = i_valid && (!is_last || i_out_free);

    // Channel k lives in bytes 2+2k (low) and 3+2k (high).
    assign in_chan = (r_pos >= POS_CHAN0) && (r_pos < POS_SUM_END);
    assign pos_off = r_pos - POS_CHAN0;
    assign chan_ix = pos_off[rcfd_pkg::POS_W-1:1];

    // Checksum test on the last byte.
    assign check_word = {i_byte, r_sum_lo};
    assign total      = r_sum + check_word;

    assign o_frame_end.valid = o_take && is_last;
    assign o_frame_end.ok    = r_hdr_ok && (total == rcfd_pkg::SUM_TARGET);

    // Next position, sum and header flag.
    always_comb begin
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_hdr_ok = r_hdr_ok;
        if (o_take) begin
            n_pos = r_pos + 5'd1;
            if (r_pos < POS_SUM_END) begin
                n_sum = r_sum + rcfd_pkg::CHAN_W'(i_byte);
            end
            if (r_pos == 5'd0) begin
                n_hdr_ok = (i_byte == rcfd_pkg::HDR0);
            end else if (r_pos == 5'd1) begin
                n_hdr_ok = r_hdr_ok && (i_byte == rcfd_pkg::HDR1);
            end
            if (is_last) begin
                n_pos    = '0;
                n_sum    = '0;
                n_hdr_ok = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_sum    <= '0;
            r_hdr_ok <= 1'b0;
            r_sum_lo <= '0;
        end else begin
            r_pos    <= n_pos;
            r_sum    <= n_sum;
            r_hdr_ok <= n_hdr_ok;
            if (o_take && (r_pos == POS_SUM_END)) begin
                r_sum_lo <= i_byte;
            end
        end
    end

    // Channel assembly; each word is fully written before the frame end.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            if (o_take && in_chan && (chan_ix == rcfd_pkg::CHIX_W'(k))) begin
                if (!r_pos[0]) begin
                    r_pending[k] <= rcfd_pkg::CHAN_W'(i_byte);
                end else begin
                    r_pending[k][rcfd_pkg::CHAN_W-1:rcfd_pkg::BYTE_W] <= i_byte;
                end
            end
        end
    end

    assign o_pending = r_pending;

    // After a frame end the tracker starts a fresh frame.
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_end.valid |=> (r_pos == '0 && r_sum == '0 && !r_hdr_ok))
        else $error("frame state not cleared after frame end");

endmodule

[rtl/core/rcfd_chan_hold.sv]
// ----------------------------------------------------------------------------
// rcfd_chan_hold: clamp limits, held channels and result register
// Clamps and latches the channel set of a good frame and loads one
// result word at each frame end.
// ----------------------------------------------------------------------------
module rcfd_chan_hold #(
    parameter int NUM_CHANNELS = rcfd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_cfg_we,
    input  logic [rcfd_pkg::CFG_IDX_W-1:0]                      i_cfg_addr,
    input  logic [rcfd_pkg::CHAN_W-1:0]                         i_cfg_wdata,
    input  rcfd_pkg::t_frame_end                                i_frame_end,
    input  logic [NUM_CHANNELS-1:0][rcfd_pkg::CHAN_W-1:0]       i_pending,
    output logic                                                o_out_free,
    output logic                                                o_m_valid,
    input  logic                                                i_m_ready,
    output logic                                                o_m_ok,
    output logic [rcfd_pkg::OUT_CHANNELS*rcfd_pkg::CHAN_W-1:0]  o_m_data
);

    localparam int OUT_W = rcfd_pkg::OUT_CHANNELS * rcfd_pkg::CHAN_W;

    logic [rcfd_pkg::CHAN_W-1:0]                   r_clamp_lo;
    logic [rcfd_pkg::CHAN_W-1:0]                   r_clamp_hi;
    logic [NUM_CHANNELS-1:0][rcfd_pkg::CHAN_W-1:0] r_held;
    logic [NUM_CHANNELS-1:0][rcfd_pkg::CHAN_W-1:0] n_held;
    logic                                          r_out_valid;
    logic                                          n_out_valid;
    logic                                          r_out_ok;
    logic [OUT_W-1:0]                              r_out_data;
    logic [OUT_W-1:0]                              n_out_data;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_lo <= rcfd_pkg::CLAMP_LOW_RST;
            r_clamp_hi <= rcfd_pkg::CLAMP_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rcfd_pkg::CFG_IDX_CLAMP_LOW: begin
                    r_clamp_lo <= i_cfg_wdata;
                end
                rcfd_pkg::CFG_IDX_CLAMP_HIGH: begin
                    r_clamp_hi <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // A good frame replaces the held set with clamped values.
    always_comb begin
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            n_held[k] = r_held[k];
            if (i_frame_end.valid && i_frame_end.ok) begin
                n_held[k] = rcfd_pkg::clamp_chan(i_pending[k], r_clamp_lo, r_clamp_hi);
            end
        end
    end

    // Result word: channels past the configured count read as zero.
    always_comb begin
        n_out_data = '0;
        for (int k = 0; k < rcfd_pkg::OUT_CHANNELS; k++) begin
            if (k < NUM_CHANNELS) begin
                n_out_data[k*rcfd_pkg::CHAN_W +: rcfd_pkg::CHAN_W] = n_held[k];
            end
        end
    end

    // Output register handshake.
    assign o_out_free = !r_out_valid || i_m_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_frame_end.valid) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame_end.valid) begin
            r_out_ok   <= i_frame_end.ok;
            r_out_data <= n_out_data;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_ok    = r_out_ok;
    assign o_m_data  = r_out_data;

    // A frame end never overwrites a result that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame_end.valid |-> (!r_out_valid || i_m_ready))
        else $error("frame result overwrote a pending result");

    // A rejected frame leaves the held channels alone.
    a_bad_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_frame_end.valid && !i_frame_end.ok) |=> $stable(r_held))
        else $error("held channels changed on a bad frame");

    // With ordered limits, a latched channel lies between them.
    a_clamp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_frame_end.valid && i_frame_end.ok && !i_cfg_we && (r_clamp_lo <= r_clamp_hi))
        |=> ((r_held[0] >= r_clamp_lo) && (r_held[0] <= r_clamp_hi)))
        else $error("held channel outside clamp limits");

endmodule

[rtl/core/rc_channel_frame_decoder.sv]
// ----------------------------------------------------------------------------
// rc_channel_frame_decoder: byte-serial RC receiver frame decoder
// Counts received bytes into 32-byte frames, checks header and checksum,
// and delivers the clamped, held channel set once per frame.
// ----------------------------------------------------------------------------
// The decoder takes one byte per clock cycle, with no gaps needed between
// bytes or frames; the input stalls only while a frame's last byte waits in
// the input register for the previous result word to be accepted, so a
// result register that empties before the next frame's last byte never
// slows the byte stream. Frame alignment starts at reset and is never
// recovered, so the first byte after reset must be a frame's first byte.
// Each byte passes an input register and is then handled combinationally
// by the frame tracker; the 32nd byte of a frame loads the result register
// when the tracker takes it, so its result word is offered in the cycle
// after that byte is taken. The result word carries frame_ok in tuser and
// the held channels in tdata; a failed frame repeats the last good channel
// set. Clamp limits must be written through the configuration port while
// the stream is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rc_channel_frame_decoder #(
    parameter int NUM_CHANNELS = rcfd_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    // Configuration write port.
    input  logic                                                i_cfg_we,
    input  logic [rcfd_pkg::CFG_IDX_W-1:0]                      i_cfg_addr,
    input  logic [rcfd_pkg::CHAN_W-1:0]                         i_cfg_wdata,
    // Received byte stream.
    input  logic                                                s_axis_tvalid,
    output logic                                                s_axis_tready,
    input  logic [rcfd_pkg::BYTE_W-1:0]                         s_axis_tdata,  // [7:0] rx_byte
    // Frame result stream.
    output logic                                                m_axis_tvalid,
    input  logic                                                m_axis_tready,
    output logic [rcfd_pkg::OUT_CHANNELS*rcfd_pkg::CHAN_W-1:0]  m_axis_tdata,
    // m_axis_tdata: [15:0] chan_0, [31:16] chan_1, ... [159:144] chan_9
    output logic                                                m_axis_tuser   // [0] frame_ok
);

    logic                                          in_valid;
    logic [rcfd_pkg::BYTE_W-1:0]                   in_byte;
    logic                                          take;
    logic                                          out_free;
    rcfd_pkg::t_frame_end                          frame_end;
    logic [NUM_CHANNELS-1:0][rcfd_pkg::CHAN_W-1:0] pending;

    rcfd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_s_byte  (s_axis_tdata),
        .o_valid   (in_valid),
        .o_byte    (in_byte),
        .i_take    (take)
    );

    rcfd_frame_track #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_frame_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_byte      (in_byte),
        .o_take      (take),
        .i_out_free  (out_free),
        .o_frame_end (frame_end),
        .o_pending   (pending)
    );

    rcfd_chan_hold #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_chan_hold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_frame_end (frame_end),
        .i_pending   (pending),
        .o_out_free  (out_free),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_m_ok      (m_axis_tuser),
        .o_m_data    (m_axis_tdata)
    );

endmodule
